FILE: design/nearest_palette_color_assert.svh
// Assertion macros used by the checker module of the palette search block.
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: design/npc_pkg.sv
// Shared types and constants of the nearest palette color search.
package npc_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int COLOR_W = 8;
	localparam int INDEX_W = 8;
	localparam int SQ_W = 2 * COLOR_W;
	localparam int DIST_W = 19;
	localparam logic [DIST_W-1:0] NO_MATCH_DISTANCE = DIST_W'(256 * 256 * 4);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic operation;
		logic [INDEX_W-1:0] entry_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [INDEX_W-1:0] range_start;
		logic [INDEX_W-1:0] range_stop;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] best_index;
	} result_t;

	// Word that moves from one cell to the next.
	typedef struct packed {
		logic valid;
		item_t item;
		logic [DIST_W-1:0] best_dist;
		logic [INDEX_W-1:0] best_index;
	} cell_bus_t;

endpackage

FILE: design/npc_stream_if.sv
// Valid/ready stream interface carrying one payload word.
interface npc_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/npc_cell.sv
// One palette cell: holds an entry, writes it on a matching load, updates the best match.
module npc_cell #(
	parameter int CELL_INDEX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input npc_pkg::cell_bus_t up,
	output npc_pkg::cell_bus_t down
);

	localparam logic [npc_pkg::INDEX_W-1:0] MY_INDEX = npc_pkg::INDEX_W'(CELL_INDEX);

	logic [npc_pkg::COLOR_W-1:0] red_q;
	logic [npc_pkg::COLOR_W-1:0] green_q;
	logic [npc_pkg::COLOR_W-1:0] blue_q;

	logic valid_q;
	npc_pkg::item_t item_q;
	logic [npc_pkg::DIST_W-1:0] best_dist_q;
	logic [npc_pkg::INDEX_W-1:0] best_index_q;

	logic [npc_pkg::COLOR_W-1:0] diff_r, diff_g, diff_b;
	logic [npc_pkg::SQ_W-1:0] sq_r, sq_g, sq_b;
	logic [npc_pkg::DIST_W-1:0] cell_dist;
	logic in_range;
	logic take;
	logic write_entry;

	always_comb begin
		diff_r = (up.item.red > red_q) ? up.item.red - red_q : red_q - up.item.red;
		diff_g = (up.item.green > green_q) ? up.item.green - green_q : green_q - up.item.green;
		diff_b = (up.item.blue > blue_q) ? up.item.blue - blue_q : blue_q - up.item.blue;
		sq_r = diff_r * diff_r;
		sq_g = diff_g * diff_g;
		sq_b = diff_b * diff_b;
		cell_dist = npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) + npc_pkg::DIST_W'(sq_b);
		in_range = (up.item.range_start <= MY_INDEX) && (MY_INDEX <= up.item.range_stop);
		// strict less-than keeps the lower index on a tie
		take = (up.item.operation == npc_pkg::OP_QUERY) && in_range
			&& (cell_dist < up.best_dist);
		write_entry = advance && up.valid && (up.item.operation == npc_pkg::OP_LOAD)
			&& (up.item.entry_index == MY_INDEX);
	end

	always_ff @(posedge clk) begin
		if (write_entry) begin
			red_q <= up.item.red;
			green_q <= up.item.green;
			blue_q <= up.item.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= up.item;
			best_dist_q <= take ? cell_dist : up.best_dist;
			best_index_q <= take ? MY_INDEX : up.best_index;
		end
	end

	assign down = '{valid: valid_q, item: item_q, best_dist: best_dist_q,
		best_index: best_index_q};

endmodule

FILE: design/nearest_palette_color.sv
// Nearest palette color search over a chain of PALETTE_ENTRIES cells, one entry per cell.
// Every word walks the whole chain, one cell per cycle while the chain is not held; loads write their cell on the way.
// Query results come from a result register behind the last cell; loads leave no result.
// Throughput: one word (load or query) per cycle; the whole chain holds on output stall.
// Reset clears the word valid bits and the result valid bit; palette entries stay undefined.
module nearest_palette_color #(
	parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	npc_stream_if.sink item,
	npc_stream_if.source result
);

	npc_pkg::cell_bus_t chain [PALETTE_ENTRIES+1];
	logic advance;
	logic res_valid_q;
	logic [npc_pkg::INDEX_W-1:0] res_index_q;

	// hold everything while a finished result waits
	assign advance = !res_valid_q || result.ready;
	assign item.ready = advance;

	assign chain[0] = '{valid: item.valid, item: item.data,
		best_dist: npc_pkg::NO_MATCH_DISTANCE, best_index: '0};

	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		npc_cell #(.CELL_INDEX(k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.up(chain[k]),
			.down(chain[k+1])
		);
	end

	// drop loads at the end of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= chain[PALETTE_ENTRIES].valid
				&& (chain[PALETTE_ENTRIES].item.operation == npc_pkg::OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_index_q <= chain[PALETTE_ENTRIES].best_index;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data.best_index = res_index_q;

endmodule

FILE: design/npc_checker.sv
// Port checker for the nearest palette color search, bound to the top level.
`include "nearest_palette_color_assert.svh"

module npc_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [npc_pkg::INDEX_W-1:0] result_index
);

	`NPC_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid)
	`NPC_ASSERT_NEXT(a_index_held, clk, arst_n, result_valid && !result_ready, $stable(result_index))
	`NPC_ASSERT_SAME(a_stall_blocks_input, clk, arst_n, result_valid && !result_ready, !item_ready)
	`NPC_ASSERT_SAME(a_idle_takes_input, clk, arst_n, !result_valid, item_ready)

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.result_index(result.data.best_index)
);

FILE: verif/tb.sv
// Self-checking testbench for the nearest palette color search block.
`timescale 1ns / 1ps

module tb;

	localparam int ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF;
	localparam int SENDER = 0;
	localparam int RECEIVER = 1;
	localparam int unsigned MAX_PAUSE = 16;
	localparam int unsigned RANDOM_WORDS = 430;
	localparam int unsigned TIMEOUT_CYCLES = 400000;

	typedef struct {
		npc_pkg::item_t word;
		bit drain_first;
	} queued_word_t;

	logic clk;
	logic arst_n;

	npc_stream_if #(.payload_t(npc_pkg::item_t)) words_in ();
	npc_stream_if #(.payload_t(npc_pkg::result_t)) nearest_out ();

	nearest_palette_color uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(words_in.sink),
		.result(nearest_out.source)
	);

	// Predictor state, updated as words are accepted.
	logic [23:0] palette_copy [ENTRIES];
	logic [npc_pkg::INDEX_W-1:0] nearest_expected [$];

	// Stimulus side: what has been queued so far.
	queued_word_t words_to_send [$];
	bit gen_written [ENTRIES];
	logic [23:0] gen_color [ENTRIES];

	int unsigned calm_left [2];
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned mismatches;

	task automatic report_mismatch(input string what);
		$display("%0t ERROR: %s", $time, what);
		mismatches++;
	endtask

	function automatic int unsigned draw_pause(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		// now and then run a stretch with no idling at all
		if ($urandom_range(0, 11) == 0) begin
			calm_left[side] = $urandom_range(15, 50);
			return 0;
		end
		return $urandom_range(0, MAX_PAUSE);
	endfunction

	function automatic logic [npc_pkg::INDEX_W-1:0] nearest_index(input npc_pkg::item_t w);
		int unsigned best_d;
		int unsigned d;
		int dr, dg, db;
		int stop;
		logic [npc_pkg::INDEX_W-1:0] best;
		logic [23:0] e;
		best_d = 32'(npc_pkg::NO_MATCH_DISTANCE);
		best = '0;
		stop = int'(w.range_stop);
		if (stop > ENTRIES - 1)
			stop = ENTRIES - 1;
		for (int i = int'(w.range_start); i <= stop; i++) begin
			e = palette_copy[i];
			dr = int'(w.red) - int'(e[23:16]);
			dg = int'(w.green) - int'(e[15:8]);
			db = int'(w.blue) - int'(e[7:0]);
			d = dr * dr + dg * dg + db * db;
			// strict compare keeps the lowest index on a tie
			if (d < best_d) begin
				best_d = d;
				best = npc_pkg::INDEX_W'(i);
			end
		end
		return best;
	endfunction

	task automatic commit_word(input npc_pkg::item_t w);
		if (w.operation == npc_pkg::OP_LOAD) begin
			if (int'(w.entry_index) < ENTRIES)
				palette_copy[w.entry_index] = {w.red, w.green, w.blue};
		end else begin
			nearest_expected.push_back(nearest_index(w));
		end
	endtask

	task automatic queue_load(input logic [7:0] idx, input logic [23:0] rgb);
		queued_word_t q;
		q.drain_first = 1'b0;
		q.word.operation = npc_pkg::OP_LOAD;
		q.word.entry_index = idx;
		{q.word.red, q.word.green, q.word.blue} = rgb;
		q.word.range_start = npc_pkg::INDEX_W'($urandom);
		q.word.range_stop = npc_pkg::INDEX_W'($urandom);
		words_to_send.push_back(q);
		gen_written[idx] = 1'b1;
		gen_color[idx] = rgb;
	endtask

	task automatic queue_query(input logic [23:0] rgb, input int start, input int stop,
			input bit drain);
		queued_word_t q;
		q.drain_first = drain;
		q.word.operation = npc_pkg::OP_QUERY;
		q.word.entry_index = npc_pkg::INDEX_W'($urandom);
		{q.word.red, q.word.green, q.word.blue} = rgb;
		q.word.range_start = npc_pkg::INDEX_W'(start);
		q.word.range_stop = npc_pkg::INDEX_W'(stop);
		words_to_send.push_back(q);
	endtask

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] near_channel(input logic [7:0] c);
		int v;
		v = int'(c) + $urandom_range(0, 6) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic int pick_written();
		int s;
		s = $urandom_range(0, ENTRIES - 1);
		for (int k = 0; k < ENTRIES; k++)
			if (gen_written[(s + k) % ENTRIES])
				return (s + k) % ENTRIES;
		return 0;
	endfunction

	task automatic queue_random_word();
		int s, lo, hi, start, stop, idx;
		logic [23:0] rgb;
		if ($urandom_range(0, 99) < 40) begin
			// grow the written region from the bottom half the time
			idx = $urandom_range(0, ENTRIES - 1);
			if ($urandom_range(0, 1) == 0)
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!gen_written[i])
						idx = i;
			if ($urandom_range(0, 4) == 0)
				rgb = gen_color[pick_written()];
			else
				rgb = {rand_channel(), rand_channel(), rand_channel()};
			queue_load(idx[7:0], rgb);
		end else if ($urandom_range(0, 99) < 15) begin
			start = $urandom_range(1, 255);
			stop = $urandom_range(0, start - 1);
			queue_query({rand_channel(), rand_channel(), rand_channel()}, start, stop,
				$urandom_range(0, 149) == 0);
		end else begin
			// search only a run of written entries
			s = pick_written();
			lo = s;
			while (lo > 0 && gen_written[lo - 1])
				lo--;
			hi = s;
			while (hi < ENTRIES - 1 && gen_written[hi + 1])
				hi++;
			if ($urandom_range(0, 9) < 4) begin
				start = lo;
				stop = hi;
			end else begin
				start = $urandom_range(lo, hi);
				stop = $urandom_range(start, hi);
			end
			if ($urandom_range(0, 9) < 4) begin
				rgb = gen_color[$urandom_range(start, stop)];
				rgb = {near_channel(rgb[23:16]), near_channel(rgb[15:8]),
					near_channel(rgb[7:0])};
			end else begin
				rgb = {rand_channel(), rand_channel(), rand_channel()};
			end
			queue_query(rgb, start, stop, $urandom_range(0, 149) == 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		words_in.valid = 1'b0;
		words_in.data = '0;
		nearest_out.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("nearest_palette_color: mismatch");
		$finish;
	end

	// Sender: present queued words, pausing between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in.valid <= 1'b0;
			words_in.data <= '0;
			gap_left = 0;
		end else begin
			if (words_in.valid && words_in.ready) begin
				commit_word(words_in.data);
				gap_left = draw_pause(SENDER);
			end
			if (!words_in.valid || words_in.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					words_in.valid <= 1'b0;
				end else if (words_to_send.size() > 0 &&
						!(words_to_send[0].drain_first && nearest_expected.size() > 0)) begin
					words_in.data <= words_to_send[0].word;
					words_in.valid <= 1'b1;
					void'(words_to_send.pop_front());
				end else begin
					words_in.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_out.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (nearest_out.valid && nearest_out.ready) begin
				if (nearest_expected.size() == 0) begin
					report_mismatch($sformatf("result %0d with no query outstanding",
						nearest_out.data.best_index));
				end else begin
					if (nearest_out.data.best_index !== nearest_expected[0])
						report_mismatch($sformatf("best_index %0d, predicted %0d",
							nearest_out.data.best_index, nearest_expected[0]));
					void'(nearest_expected.pop_front());
				end
				stall_left = draw_pause(RECEIVER);
			end
			if (stall_left > 0) begin
				stall_left--;
				nearest_out.ready <= 1'b0;
			end else begin
				nearest_out.ready <= 1'b1;
			end
		end
	end

	initial begin
		mismatches = 0;
		calm_left[SENDER] = 0;
		calm_left[RECEIVER] = 0;

		// Directed: extremes, ties, exact hits, single entry and empty ranges.
		queue_load(8'd0, 24'h000000);
		queue_load(8'd1, 24'hffffff);
		queue_load(8'd2, 24'h000000);
		queue_load(8'd3, 24'hff0000);
		queue_load(8'd4, 24'h00ff00);
		queue_load(8'd5, 24'h0000ff);
		queue_load(8'd6, 24'h808080);
		queue_load(8'd254, 24'h7f7f7f);
		queue_load(8'd255, 24'h010203);
		queue_query(24'h000000, 0, 6, 1'b0);
		queue_query(24'h000000, 1, 6, 1'b0);
		queue_query(24'hffffff, 0, 0, 1'b0);
		queue_query(24'hffffff, 0, 6, 1'b0);
		queue_query(24'hfe0101, 0, 6, 1'b0);
		queue_query(24'h808080, 0, 1, 1'b0);
		queue_query(24'h123456, 4, 4, 1'b0);
		queue_query(24'h808080, 6, 5, 1'b0);
		queue_query(24'hffffff, 255, 0, 1'b1);
		queue_query(24'h000000, 254, 255, 1'b0);
		queue_query(24'h7f7f7f, 254, 255, 1'b0);

		for (int n = 0; n < RANDOM_WORDS; n++)
			queue_random_word();

		@(posedge arst_n);
		while (words_to_send.size() > 0 || words_in.valid)
			@(posedge clk);
		while (nearest_expected.size() > 0)
			@(posedge clk);
		// catch any stray result still in the chain
		repeat (ENTRIES + 20) @(posedge clk);

		if (mismatches == 0) begin
			$display("nearest_palette_color: match");
		end else begin
			$display("nearest_palette_color: mismatch");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/npc_pkg.sv
design/npc_stream_if.sv
design/npc_cell.sv
design/nearest_palette_color.sv
design/npc_checker.sv
verif/tb.sv
